[src/ddeo_pkg.sv]
package ddeo_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SUM,
        S_MUL_DIFF,
        S_MUL_TH,
        S_TURN_A,
        S_TURN_B,
        S_CORD_MID,
        S_MUL_X,
        S_MUL_Y,
        S_MUL_LIN,
        S_DIV_LIN,
        S_MUL_ANG,
        S_DIV_ANG,
        S_CORD_QUAT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        CMD_LEFT   = 2'd0,
        CMD_RIGHT  = 2'd1,
        CMD_UPDATE = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    localparam logic [1:0] CFG_MPT  = 2'd0;
    localparam logic [1:0] CFG_ISEP = 2'd1;
    localparam logic [1:0] CFG_MAX  = 2'd2;

    localparam logic [23:0] MPT_RESET  = 24'd167772;
    localparam logic [23:0] ISEP_RESET = 24'd436907;
    localparam logic [15:0] MAX_RESET  = 16'd1000;

    // 2*pi in Q32 radians
    localparam logic [34:0] TWO_PI_Q32   = 35'd26986075409;
    localparam logic [31:0] CORDIC_START = 32'd652032874;
    localparam logic [9:0]  VEL_SCALE    = 10'd1000;
    localparam int          TURN_FRAC    = 28;

    // atan(2^-i) as a fraction of a turn, 2^32 per turn
    function automatic logic [31:0] atan_at(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[src/diff_drive_encoder_odometry.sv]
// encoder edge transfers give no result
// accepted pose update: the time from input transfer to result valid is set by
//   the shared bit-serial multiplier (seven products),
//   the bit-serial divider (six passes) and the iterative cordic
// rejected update: runs only the quaternion cordic pass, then waits while an earlier result is held by stall
// synchronous active-low reset clears counters, pose, velocities and loads register defaults
module diff_drive_encoder_odometry #(
    parameter int COUNT_WIDTH    = 16,
    parameter int POSITION_WIDTH = 32,
    parameter int CORDIC_STEPS   = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_cmd,
    input  logic signed [1:0]  i_direction,
    input  logic [15:0]        i_elapsed_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_pos_x,
    output logic signed [31:0] o_pos_y,
    output logic signed [15:0] o_heading,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_turn_rate,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_z,
    output logic               o_pose_updated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int CW     = COUNT_WIDTH;
    localparam int SW     = COUNT_WIDTH + 1;
    localparam int MB_W   = 34;
    localparam int PW     = 75;
    localparam int DTH_W  = 56;
    localparam int DW     = 56;
    localparam int VW     = 35;
    localparam int CNT_W  = 6;
    localparam int XW     = 34;
    localparam int ZW     = 34;
    localparam int POS_W  = POSITION_WIDTH;

    localparam logic signed [CW-1:0] CNT_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CNT_MIN = {1'b1, {(CW-1){1'b0}}};

    localparam logic signed [PW-1:0] HALF_8  = PW'(1) <<< 7;
    localparam logic signed [PW-1:0] HALF_9  = PW'(1) <<< 8;
    localparam logic signed [PW-1:0] HALF_16 = PW'(1) <<< 15;
    localparam logic signed [PW-1:0] HALF_30 = PW'(1) <<< 29;
    localparam logic signed [PW-1:0] DS_HI   = (PW'(1) <<< 32) - PW'(1);
    localparam logic signed [PW-1:0] DS_LO   = -(PW'(1) <<< 32);
    localparam logic signed [PW-1:0] DIF_HI  = PW'(1) <<< 38;
    localparam logic signed [PW-1:0] DIF_LO  = -(PW'(1) <<< 38);
    localparam logic signed [PW-1:0] POS_HI  = (PW'(1) <<< (POS_W-1)) - PW'(1);
    localparam logic signed [PW-1:0] POS_LO  = -(PW'(1) <<< (POS_W-1));
    localparam logic signed [PW-1:0] V_HI    = (PW'(1) <<< 31) - PW'(1);
    localparam logic signed [PW-1:0] V_LO    = -(PW'(1) <<< 31);
    localparam logic signed [ZW-1:0] Z_QTR   = ZW'(1) <<< 30;
    localparam logic signed [ZW-1:0] Z_HALF  = ZW'(1) <<< 31;

    ddeo_pkg::t_state r_state, n_state;

    logic [23:0] r_mpt, r_isep;
    logic [15:0] r_max;

    logic signed [CW-1:0]    r_left, r_right;
    logic signed [POS_W-1:0] r_pos_x, r_pos_y;
    logic [15:0]             r_heading;
    logic signed [31:0]      r_lin, r_ang;

    logic [15:0]              r_ms;
    logic                     r_ok;
    logic signed [SW-1:0]     r_dif_cnt;
    logic signed [32:0]       r_ds;
    logic signed [DTH_W-1:0]  r_dth;
    logic [CNT_W-1:0]         r_cnt;

    logic signed [PW-1:0] r_mul_acc, r_mul_a;
    logic [MB_W-1:0]      r_mul_b;

    logic [VW-1:0] r_div_rem, r_div_v;
    logic [DW-1:0] r_div_dvd;
    logic          r_div_neg;
    logic          r_turn_hd;

    logic signed [XW-1:0] r_cx, r_cy, r_sin;
    logic signed [ZW-1:0] r_cz;
    logic                 r_flip;

    logic               r_out_valid;
    logic signed [31:0] r_o_x, r_o_y, r_o_lin, r_o_ang;
    logic [15:0]        r_o_hd, r_o_qw, r_o_qz;
    logic               r_o_ok;

    logic in_xfer, w_ok, w_last, w_out_free;
    logic signed [1:0] w_dir;

    logic signed [PW-1:0] w_mul_add, w_mul_next;
    logic signed [PW-1:0] w_ds_r, w_dif_sat, w_dth_full, w_rnd30, w_w;
    logic signed [PW-1:0] w_px_sum, w_py_sum, w_px_sat, w_py_sat;
    logic signed [PW-1:0] w_turn_src, w_turn_mag, w_num_mag, w_q_ext, w_vel, w_vel_sat;
    logic signed [PW-1:0] w_px_ext, w_py_ext;
    logic [VW:0]          w_div_t;
    logic                 w_div_ge;
    logic [VW-1:0]        w_div_rem_n, w_turn_r;
    logic [31:0]          w_turn, w_mid, w_qang, w_fold_in, w_hd_sum;
    logic signed [ZW-1:0] w_z0, w_zf, w_atan;
    logic                 w_flip0;
    logic signed [XW-1:0] w_cx_sh, w_cy_sh, w_cx_out, w_cy_out;
    logic signed [XW-1:0] w_qw_r, w_qz_r;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ddeo_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_ok        = (i_elapsed_ms != 16'd0) && (i_elapsed_ms <= r_max);
    assign w_dir       = (i_direction == 2'sd1) ? 2'sd1 :
                         ((i_direction == 2'sd0) ? 2'sd0 : -2'sd1);

    // shared signed shift-add multiplier, sign bit of b weighs negative
    assign w_mul_add  = r_mul_b[0] ? ((r_cnt == CNT_W'(MB_W-1)) ? -r_mul_a : r_mul_a)
                                   : '0;
    assign w_mul_next = r_mul_acc + w_mul_add;

    assign w_ds_r     = (r_mul_acc + HALF_9) >>> 9;
    assign w_dif_sat  = (r_mul_acc > DIF_HI) ? DIF_HI :
                        ((r_mul_acc < DIF_LO) ? DIF_LO : r_mul_acc);
    assign w_dth_full = (r_mul_acc + HALF_8) >>> 8;
    assign w_rnd30    = (r_mul_acc + HALF_30) >>> 30;
    assign w_w        = (PW'(r_dth) + HALF_16) >>> 16;

    assign w_px_sum = PW'(r_pos_x) + w_rnd30;
    assign w_py_sum = PW'(r_pos_y) + w_rnd30;
    assign w_px_sat = (w_px_sum > POS_HI) ? POS_HI : ((w_px_sum < POS_LO) ? POS_LO : w_px_sum);
    assign w_py_sat = (w_py_sum > POS_HI) ? POS_HI : ((w_py_sum < POS_LO) ? POS_LO : w_py_sum);

    // floor mod of negative x uses ~x, remainder mapped back as 2pi-1-m
    assign w_turn_src = (r_state == ddeo_pkg::S_MUL_TH) ? (w_dth_full >>> 1) : PW'(r_dth);
    assign w_turn_mag = w_turn_src[PW-1] ? ~w_turn_src : w_turn_src;
    assign w_turn_r   = r_div_neg ? (ddeo_pkg::TWO_PI_Q32 - VW'(1) - r_div_rem) : r_div_rem;
    assign w_turn     = {r_div_dvd[ddeo_pkg::TURN_FRAC-1:0], 4'b0000};
    assign w_mid      = {r_heading, 16'h0000} + w_turn;
    assign w_qang     = {r_heading[15], r_heading, 15'h0000};
    assign w_hd_sum   = w_turn + 32'h0000_8000;

    assign w_num_mag = r_mul_acc[PW-1] ? -r_mul_acc : r_mul_acc;
    assign w_q_ext   = PW'(r_div_dvd);
    assign w_vel     = r_div_neg ? -w_q_ext : w_q_ext;
    assign w_vel_sat = (w_vel > V_HI) ? V_HI : ((w_vel < V_LO) ? V_LO : w_vel);

    // restoring divider, one quotient bit per cycle
    assign w_div_t     = {r_div_rem, r_div_dvd[DW-1]};
    assign w_div_ge    = (w_div_t >= {1'b0, r_div_v});
    assign w_div_rem_n = w_div_ge ? VW'(w_div_t - {1'b0, r_div_v}) : VW'(w_div_t);

    // cordic load with the angle folded into a half turn around zero
    assign w_fold_in = (r_state == ddeo_pkg::S_TURN_B) ? w_mid : w_qang;
    assign w_z0      = ZW'($signed(w_fold_in));
    assign w_flip0   = (w_z0 > Z_QTR) || (w_z0 < -Z_QTR);
    assign w_zf      = (w_z0 > Z_QTR) ? (w_z0 - Z_HALF) :
                       ((w_z0 < -Z_QTR) ? (w_z0 + Z_HALF) : w_z0);
    assign w_atan    = $signed(ZW'(ddeo_pkg::atan_at(r_cnt[4:0])));
    assign w_cx_sh   = r_cx >>> r_cnt;
    assign w_cy_sh   = r_cy >>> r_cnt;
    assign w_cx_out  = r_flip ? -r_cx : r_cx;
    assign w_cy_out  = r_flip ? -r_cy : r_cy;
    assign w_qw_r    = (w_cx_out + XW'(32768)) >>> 16;
    assign w_qz_r    = (w_cy_out + XW'(32768)) >>> 16;

    always_comb begin
        case (r_state)
            ddeo_pkg::S_MUL_SUM, ddeo_pkg::S_MUL_DIFF, ddeo_pkg::S_MUL_TH,
            ddeo_pkg::S_MUL_X, ddeo_pkg::S_MUL_Y, ddeo_pkg::S_MUL_LIN,
            ddeo_pkg::S_MUL_ANG: begin
                w_last = (r_cnt == CNT_W'(MB_W));
            end
            ddeo_pkg::S_TURN_A, ddeo_pkg::S_DIV_LIN, ddeo_pkg::S_DIV_ANG: begin
                w_last = (r_cnt == CNT_W'(DW));
            end
            ddeo_pkg::S_TURN_B: begin
                w_last = (r_cnt == CNT_W'(ddeo_pkg::TURN_FRAC));
            end
            ddeo_pkg::S_CORD_MID, ddeo_pkg::S_CORD_QUAT: begin
                w_last = (r_cnt == CNT_W'(CORDIC_STEPS));
            end
            default: begin
                w_last = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ddeo_pkg::S_IDLE: begin
                if (in_xfer && i_cmd == ddeo_pkg::CMD_UPDATE) begin
                    n_state = w_ok ? ddeo_pkg::S_MUL_SUM : ddeo_pkg::S_CORD_QUAT;
                end
            end
            ddeo_pkg::S_MUL_SUM:   if (w_last) n_state = ddeo_pkg::S_MUL_DIFF;
            ddeo_pkg::S_MUL_DIFF:  if (w_last) n_state = ddeo_pkg::S_MUL_TH;
            ddeo_pkg::S_MUL_TH:    if (w_last) n_state = ddeo_pkg::S_TURN_A;
            ddeo_pkg::S_TURN_A:    if (w_last) n_state = ddeo_pkg::S_TURN_B;
            ddeo_pkg::S_TURN_B: begin
                if (w_last) n_state = r_turn_hd ? ddeo_pkg::S_MUL_LIN : ddeo_pkg::S_CORD_MID;
            end
            ddeo_pkg::S_CORD_MID:  if (w_last) n_state = ddeo_pkg::S_MUL_X;
            ddeo_pkg::S_MUL_X:     if (w_last) n_state = ddeo_pkg::S_MUL_Y;
            ddeo_pkg::S_MUL_Y:     if (w_last) n_state = ddeo_pkg::S_TURN_A;
            ddeo_pkg::S_MUL_LIN:   if (w_last) n_state = ddeo_pkg::S_DIV_LIN;
            ddeo_pkg::S_DIV_LIN:   if (w_last) n_state = ddeo_pkg::S_MUL_ANG;
            ddeo_pkg::S_MUL_ANG:   if (w_last) n_state = ddeo_pkg::S_DIV_ANG;
            ddeo_pkg::S_DIV_ANG:   if (w_last) n_state = ddeo_pkg::S_CORD_QUAT;
            ddeo_pkg::S_CORD_QUAT: if (w_last) n_state = ddeo_pkg::S_OUT;
            ddeo_pkg::S_OUT:       if (w_out_free) n_state = ddeo_pkg::S_IDLE;
            default: n_state = ddeo_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddeo_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mpt     <= ddeo_pkg::MPT_RESET;
            r_isep    <= ddeo_pkg::ISEP_RESET;
            r_max     <= ddeo_pkg::MAX_RESET;
            r_left    <= '0;
            r_right   <= '0;
            r_pos_x   <= '0;
            r_pos_y   <= '0;
            r_heading <= '0;
            r_lin     <= '0;
            r_ang     <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    ddeo_pkg::CFG_MPT:  r_mpt  <= i_cfg_data[23:0];
                    ddeo_pkg::CFG_ISEP: r_isep <= i_cfg_data[23:0];
                    ddeo_pkg::CFG_MAX:  r_max  <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (in_xfer) begin
                case (i_cmd)
                    ddeo_pkg::CMD_LEFT: begin
                        if (!((w_dir == 2'sd1 && r_left == CNT_MAX) ||
                              (w_dir == -2'sd1 && r_left == CNT_MIN))) begin
                            r_left <= r_left + CW'(w_dir);
                        end
                    end
                    ddeo_pkg::CMD_RIGHT: begin
                        if (!((w_dir == 2'sd1 && r_right == CNT_MAX) ||
                              (w_dir == -2'sd1 && r_right == CNT_MIN))) begin
                            r_right <= r_right + CW'(w_dir);
                        end
                    end
                    ddeo_pkg::CMD_UPDATE: begin
                        if (w_ok) begin
                            r_left  <= '0;
                            r_right <= '0;
                        end
                    end
                    default: ;
                endcase
            end
            if (w_last) begin
                case (r_state)
                    ddeo_pkg::S_MUL_X: r_pos_x <= w_px_sat[POS_W-1:0];
                    ddeo_pkg::S_MUL_Y: r_pos_y <= w_py_sat[POS_W-1:0];
                    ddeo_pkg::S_TURN_B: begin
                        if (r_turn_hd) r_heading <= r_heading + w_hd_sum[31:16];
                    end
                    ddeo_pkg::S_DIV_LIN: r_lin <= w_vel_sat[31:0];
                    ddeo_pkg::S_DIV_ANG: r_ang <= w_vel_sat[31:0];
                    default: ;
                endcase
            end
        end
    end

    // serial datapath: operand loads at the end of each pass
    always_ff @(posedge i_clk) begin
        case (r_state)
            ddeo_pkg::S_IDLE: begin
                if (in_xfer && i_cmd == ddeo_pkg::CMD_UPDATE) begin
                    r_ms      <= i_elapsed_ms;
                    r_ok      <= w_ok;
                    r_cnt     <= '0;
                    r_dif_cnt <= SW'(r_right) - SW'(r_left);
                    r_mul_acc <= '0;
                    r_mul_a   <= PW'(SW'(r_left) + SW'(r_right));
                    r_mul_b   <= MB_W'(r_mpt);
                    r_cx      <= XW'(ddeo_pkg::CORDIC_START);
                    r_cy      <= '0;
                    r_cz      <= w_zf;
                    r_flip    <= w_flip0;
                end
            end
            ddeo_pkg::S_MUL_SUM, ddeo_pkg::S_MUL_DIFF, ddeo_pkg::S_MUL_TH,
            ddeo_pkg::S_MUL_X, ddeo_pkg::S_MUL_Y, ddeo_pkg::S_MUL_LIN,
            ddeo_pkg::S_MUL_ANG: begin
                if (!w_last) begin
                    r_mul_acc <= w_mul_next;
                    r_mul_a   <= r_mul_a <<< 1;
                    r_mul_b   <= r_mul_b >> 1;
                    r_cnt     <= r_cnt + CNT_W'(1);
                end else begin
                    r_cnt     <= '0;
                    r_mul_acc <= '0;
                    r_div_rem <= '0;
                    case (r_state)
                        ddeo_pkg::S_MUL_SUM: begin
                            r_ds    <= (w_ds_r > DS_HI) ? 33'(DS_HI) :
                                       ((w_ds_r < DS_LO) ? 33'(DS_LO) : w_ds_r[32:0]);
                            r_mul_a <= PW'(r_dif_cnt);
                            r_mul_b <= MB_W'(r_mpt);
                        end
                        ddeo_pkg::S_MUL_DIFF: begin
                            r_mul_a <= w_dif_sat;
                            r_mul_b <= MB_W'(r_isep);
                        end
                        ddeo_pkg::S_MUL_TH: begin
                            r_dth     <= w_dth_full[DTH_W-1:0];
                            r_div_dvd <= w_turn_mag[DW-1:0];
                            r_div_neg <= w_turn_src[PW-1];
                            r_div_v   <= ddeo_pkg::TWO_PI_Q32;
                            r_turn_hd <= 1'b0;
                        end
                        ddeo_pkg::S_MUL_X: begin
                            r_mul_a <= PW'(r_ds);
                            r_mul_b <= r_sin;
                        end
                        ddeo_pkg::S_MUL_Y: begin
                            r_div_dvd <= w_turn_mag[DW-1:0];
                            r_div_neg <= w_turn_src[PW-1];
                            r_div_v   <= ddeo_pkg::TWO_PI_Q32;
                            r_turn_hd <= 1'b1;
                        end
                        default: begin
                            // both velocity products go to the divider by elapsed ms
                            r_div_dvd <= w_num_mag[DW-1:0];
                            r_div_neg <= r_mul_acc[PW-1];
                            r_div_v   <= VW'(r_ms);
                        end
                    endcase
                end
            end
            ddeo_pkg::S_TURN_A, ddeo_pkg::S_TURN_B, ddeo_pkg::S_DIV_LIN,
            ddeo_pkg::S_DIV_ANG: begin
                if (!w_last) begin
                    r_div_rem <= w_div_rem_n;
                    r_div_dvd <= {r_div_dvd[DW-2:0], w_div_ge};
                    r_cnt     <= r_cnt + CNT_W'(1);
                end else begin
                    r_cnt <= '0;
                    case (r_state)
                        ddeo_pkg::S_TURN_A: begin
                            r_div_rem <= w_turn_r;
                            r_div_dvd <= '0;
                        end
                        ddeo_pkg::S_TURN_B: begin
                            r_mul_acc <= '0;
                            r_mul_a   <= PW'(r_ds);
                            r_mul_b   <= MB_W'(ddeo_pkg::VEL_SCALE);
                            r_cx      <= XW'(ddeo_pkg::CORDIC_START);
                            r_cy      <= '0;
                            r_cz      <= w_zf;
                            r_flip    <= w_flip0;
                        end
                        ddeo_pkg::S_DIV_LIN: begin
                            r_mul_acc <= '0;
                            r_mul_a   <= w_w;
                            r_mul_b   <= MB_W'(ddeo_pkg::VEL_SCALE);
                        end
                        default: begin
                            r_cx   <= XW'(ddeo_pkg::CORDIC_START);
                            r_cy   <= '0;
                            r_cz   <= w_zf;
                            r_flip <= w_flip0;
                        end
                    endcase
                end
            end
            ddeo_pkg::S_CORD_MID, ddeo_pkg::S_CORD_QUAT: begin
                if (!w_last) begin
                    if (r_cz >= 0) begin
                        r_cx <= r_cx - w_cy_sh;
                        r_cy <= r_cy + w_cx_sh;
                        r_cz <= r_cz - w_atan;
                    end else begin
                        r_cx <= r_cx + w_cy_sh;
                        r_cy <= r_cy - w_cx_sh;
                        r_cz <= r_cz + w_atan;
                    end
                    r_cnt <= r_cnt + CNT_W'(1);
                end else begin
                    r_cnt <= '0;
                    if (r_state == ddeo_pkg::S_CORD_MID) begin
                        r_mul_acc <= '0;
                        r_mul_a   <= PW'(r_ds);
                        r_mul_b   <= w_cx_out;
                        r_sin     <= w_cy_out;
                    end
                end
            end
            default: ;
        endcase
    end

    // result register parts the sequencer from the output stall
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ddeo_pkg::S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // cordic registers hold their final values while waiting in the output state
    always_ff @(posedge i_clk) begin
        if (r_state == ddeo_pkg::S_OUT && w_out_free) begin
            r_o_x   <= w_px_ext[31:0];
            r_o_y   <= w_py_ext[31:0];
            r_o_hd  <= r_heading;
            r_o_lin <= r_lin;
            r_o_ang <= r_ang;
            r_o_qw  <= w_qw_r[15:0];
            r_o_qz  <= w_qz_r[15:0];
            r_o_ok  <= r_ok;
        end
    end

    assign w_px_ext = PW'(r_pos_x);
    assign w_py_ext = PW'(r_pos_y);

    assign o_out_valid        = r_out_valid;
    assign o_pos_x            = r_o_x;
    assign o_pos_y            = r_o_y;
    assign o_heading          = r_o_hd;
    assign o_linear_velocity  = r_o_lin;
    assign o_turn_rate        = r_o_ang;
    assign o_quat_w           = r_o_qw;
    assign o_quat_z           = r_o_qz;
    assign o_pose_updated     = r_o_ok;

    a_update_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_cmd == ddeo_pkg::CMD_UPDATE) |=> (r_state != ddeo_pkg::S_IDLE))
        else $error("update transfer did not start the sequencer");

    a_counts_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddeo_pkg::S_MUL_SUM) |-> (r_left == '0 && r_right == '0))
        else $error("tick counters not cleared by accepted update");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ddeo_pkg::S_DIV_LIN || r_state == ddeo_pkg::S_DIV_ANG) |->
        (r_div_rem < r_div_v))
        else $error("divider remainder reached divisor");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> (r_out_valid && $stable(r_o_x) && $stable(r_o_qw)))
        else $error("stalled result was overwritten");

endmodule
